>>> hw/rtl/lsar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the seeded additive random generator.
// No dependencies; the datapath, controller, top level and bench take names from here by scope.
package lsar_pkg;

  // Multiplier A = 5^41 as three 32-bit words, least significant first
  localparam logic [31:0] MultW0 = 32'h5aa1cae5;
  localparam logic [31:0] MultW1 = 32'hd0cf37be;
  localparam logic [31:0] MultW2 = 32'h92efd1b8;

  localparam int TableSize = 63;
  localparam int Lag       = 5;
  localparam int PosW      = 6;

  localparam logic [PosW-1:0] PosReset = PosW'(1);

  typedef logic [PosW-1:0] pos_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // take seed, work out positions, start the LCG
    logic mul;   // register the partial products of A*X
    logic acc;   // sum partial products into X, capture entries
    logic emit;  // move the sum of the two entries to the output
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;  // current LCG step reaches the later entry
  } sts_t;

endpackage

>>> hw/rtl/lsar_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result transactions.
// Depends on nothing.
interface lsar_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] caller_seed;
  logic [31:0] source_seed;

  modport source (output valid, output caller_seed, output source_seed, input ready);
  modport sink   (input valid, input caller_seed, input source_seed, output ready);
endinterface

interface lsar_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

>>> hw/rtl/lcg96_seeded_additive_random.sv
`timescale 1ns / 1ps
// Top level of the seeded additive random generator on a 96-bit LCG table.
// Depends on lsar_pkg, lsar_if, lsar_ctrl and lsar_dp.
//
//   channel   direction  payload                          handshake
//   in_req    sink       caller_seed[31:0], source_seed   valid/ready
//   out_rsp   source     random_value[63:0]               valid/ready
//
// Each transaction runs the LCG step loop from entry 0 up to max(i, j);
// each step registers the partial products, then accumulates them.
// Reset sets the table position to one and leaves no result pending.
// A new request is taken while a finished result waits in the output
// register; a result that cannot leave holds the controller until it can.
module lcg96_seeded_additive_random (
  input logic       clk,
  input logic       rst_n,
  lsar_req_if.sink  in_req,
  lsar_rsp_if.source out_rsp
);

  lsar_pkg::cmd_t cmd;
  lsar_pkg::sts_t sts;

  lsar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lsar_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .caller_seed  (in_req.caller_seed),
    .source_seed  (in_req.source_seed),
    .random_value (out_rsp.random_value)
  );

endmodule

>>> hw/rtl/lsar_dp.sv
`timescale 1ns / 1ps
// Datapath: 96-bit LCG state, partial products, captured entries, position
// and output register. Depends on lsar_pkg.
module lsar_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  lsar_pkg::cmd_t    cmd,
  output lsar_pkg::sts_t    sts,
  input  logic [31:0]       caller_seed,
  input  logic [31:0]       source_seed,
  output logic [63:0]       random_value
);

  logic [95:0]         x_r, x_nxt;
  logic [63:0]         p00_r, p01_r, p10_r, p02_r, p11_r, p20_r;
  logic [63:0]         ent_i_r, ent_j_r, out_r;
  lsar_pkg::pos_t      pos_r, pos_nxt;
  lsar_pkg::pos_t      i_r, j_r, max_r, step_r;
  lsar_pkg::pos_t      j_w, max_w;
  logic [lsar_pkg::PosW:0] j_sum;
  logic [95:0]         acc_sum;
  logic [63:0]         entry;

  // Partner position, wrapped once: Lag stays below TableSize
  always_comb begin
    j_sum = {1'b0, pos_r} + (lsar_pkg::PosW + 1)'(lsar_pkg::Lag);
    if (j_sum >= (lsar_pkg::PosW + 1)'(lsar_pkg::TableSize)) begin
      j_w = lsar_pkg::PosW'(j_sum - (lsar_pkg::PosW + 1)'(lsar_pkg::TableSize));
    end else begin
      j_w = lsar_pkg::PosW'(j_sum);
    end
    max_w = (j_w > pos_r) ? j_w : pos_r;
    if (pos_r == lsar_pkg::PosW'(lsar_pkg::TableSize - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + lsar_pkg::PosW'(1);
    end
  end

  // A*X + 1 mod 2^96 from the six partial products that stay below 2^96
  always_comb begin
    acc_sum = 96'd1 + {32'd0, p00_r} + {p01_r, 32'd0} + {p10_r, 32'd0}
            + {p02_r[31:0], 64'd0} + {p11_r[31:0], 64'd0} + {p20_r[31:0], 64'd0};
    // swap words: bits 95..64 low, bits 63..32 high; entry 0 forced odd
    entry = {acc_sum[63:32], acc_sum[95:64]} | {63'd0, (step_r == '0)};
  end

  always_comb begin
    x_nxt = x_r;
    if (cmd.load) begin
      x_nxt = {64'd0, (source_seed != 32'd0) ? source_seed : caller_seed};
    end else if (cmd.acc) begin
      x_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= lsar_pkg::PosReset;
    end else if (cmd.load) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (cmd.load) begin
      i_r    <= pos_r;
      j_r    <= j_w;
      max_r  <= max_w;
      step_r <= '0;
    end
    if (cmd.mul) begin
      p00_r <= 64'(lsar_pkg::MultW0) * 64'(x_r[31:0]);
      p01_r <= 64'(lsar_pkg::MultW0) * 64'(x_r[63:32]);
      p02_r <= 64'(lsar_pkg::MultW0) * 64'(x_r[95:64]);
      p10_r <= 64'(lsar_pkg::MultW1) * 64'(x_r[31:0]);
      p11_r <= 64'(lsar_pkg::MultW1) * 64'(x_r[63:32]);
      p20_r <= 64'(lsar_pkg::MultW2) * 64'(x_r[31:0]);
    end
    if (cmd.acc) begin
      step_r <= step_r + lsar_pkg::PosW'(1);
      if (step_r == i_r) ent_i_r <= entry;
      if (step_r == j_r) ent_j_r <= entry;
    end
    if (cmd.emit) begin
      out_r <= ent_i_r + ent_j_r;
    end
  end

  assign sts.last     = (step_r == max_r);
  assign random_value = out_r;

endmodule

>>> hw/rtl/lsar_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, multiply/accumulate steps and output hand-off.
// Depends on lsar_pkg.
module lsar_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lsar_pkg::cmd_t cmd,
  input  lsar_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ACC  = 4'b0100,
    S_SUM  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_SUM : S_MUL;
      end
      S_SUM: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted request did not start the LCG");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result valid without emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(cmd.emit))
    else $error("pending result overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for lcg96_seeded_additive_random: seeds in, 64-bit draws out.
// Depends on lsar_pkg, lsar_if and the generator RTL; predicts each draw from the
// 96-bit LCG table and checks it against the result channel in order.
module tb_top;

  // A = 5^41, low 96 bits
  localparam logic [95:0] LcgMul = 96'h92efd1b8_d0cf37be_5aa1cae5;

  localparam int RandomReqs  = 1150;
  localparam int HoldAt      = 150;   // results seen before the long receiver hold-off
  localparam int HoldCycles  = 600;
  localparam int QuietLo     = 600;   // window with no idling on either side
  localparam int QuietHi     = 800;
  localparam int IdlePct     = 38;
  localparam int SettleCycles = 200;

  typedef struct {
    logic [31:0] caller_seed;
    logic [31:0] source_seed;
    bit          drain;       // wait for all results before offering this one
  } seed_req_t;

  logic clk = 1'b0;
  logic rst_n;

  lsar_req_if in_req ();
  lsar_rsp_if out_rsp ();

  lcg96_seeded_additive_random dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  seed_req_t      pending_reqs[$];
  logic [63:0]    expected_draws[$];
  lsar_pkg::pos_t draw_pos;
  int             reqs_total;
  int             reqs_taken;
  int             draws_seen;
  int             mismatches;
  int             hold_left;
  bit             held_once;
  bit             offer;
  bit             take;
  seed_req_t      next_req;
  logic [63:0]    want;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Build the table from the chosen seed and sum the entries at pos_i and its lag partner
  function automatic logic [63:0] additive_draw(input logic [31:0] seed,
                                                input int unsigned pos_i);
    logic [95:0] x;
    logic [63:0] ent;
    logic [63:0] ent_i;
    logic [63:0] ent_j;
    int unsigned pos_j;
    pos_j = (pos_i + lsar_pkg::Lag) % lsar_pkg::TableSize;
    x = {64'd0, seed};
    ent_i = '0;
    ent_j = '0;
    for (int k = 0; k < lsar_pkg::TableSize; k++) begin
      x = x * LcgMul + 96'd1;
      ent = {x[63:32], x[95:64]};
      if (k == 0) ent[0] = 1'b1;
      if (k == pos_i) ent_i = ent;
      if (k == pos_j) ent_j = ent;
    end
    return ent_j + ent_i;
  endfunction

  function automatic bit roll_idle(input int count);
    if (count >= QuietLo && count < QuietHi) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid       <= 1'b0;
      in_req.caller_seed <= '0;
      in_req.source_seed <= '0;
      draw_pos           <= lsar_pkg::PosReset;
    end else begin
      offer = in_req.valid && !in_req.ready;
      if (in_req.valid && in_req.ready) begin
        expected_draws.push_back(additive_draw(
            (in_req.source_seed != 0) ? in_req.source_seed : in_req.caller_seed,
            int'(draw_pos) % lsar_pkg::TableSize));
        draw_pos <= lsar_pkg::pos_t'(
            (int'(draw_pos) % lsar_pkg::TableSize + 1) % lsar_pkg::TableSize);
        reqs_taken++;
      end
      if (!offer && pending_reqs.size() != 0 && !roll_idle(reqs_taken)) begin
        if (!pending_reqs[0].drain || expected_draws.size() == 0) begin
          next_req = pending_reqs.pop_front();
          in_req.caller_seed <= next_req.caller_seed;
          in_req.source_seed <= next_req.source_seed;
          offer = 1'b1;
        end
      end
      in_req.valid <= offer;
    end
  end

  // Result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      hold_left     = 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        draws_seen++;
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("unexpected draw %h", out_rsp.random_value));
        end else begin
          want = expected_draws.pop_front();
          if (out_rsp.random_value !== want)
            report_mismatch($sformatf("draw %0d: random_value %h, want %h",
                                      draws_seen, out_rsp.random_value, want));
        end
      end
      // hold off long enough to back the block up into its input
      if (draws_seen == HoldAt && !held_once) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        take = !roll_idle(draws_seen);
      end
      out_rsp.ready <= take;
    end
  end

  function automatic seed_req_t mk_req(input logic [31:0] caller, input logic [31:0] source,
                                       input bit drain = 1'b0);
    seed_req_t r;
    r.caller_seed = caller;
    r.source_seed = source;
    r.drain       = drain;
    return r;
  endfunction

  initial begin
    in_req.valid       = 1'b0;
    in_req.caller_seed = '0;
    in_req.source_seed = '0;
    out_rsp.ready      = 1'b0;
    rst_n              = 1'b0;
    reqs_taken = 0;
    draws_seen = 0;
    mismatches = 0;
    held_once  = 1'b0;

    // both seeds zero, field extremes, override by the hardware seed
    pending_reqs.push_back(mk_req(32'h0000_0000, 32'h0000_0000));
    pending_reqs.push_back(mk_req(32'hffff_ffff, 32'h0000_0000));
    pending_reqs.push_back(mk_req(32'h0000_0000, 32'hffff_ffff));
    pending_reqs.push_back(mk_req(32'h0000_0001, 32'h0000_0000));
    pending_reqs.push_back(mk_req(32'h0000_0000, 32'h0000_0001));
    pending_reqs.push_back(mk_req(32'h8000_0000, 32'h0000_0000));
    pending_reqs.push_back(mk_req(32'h0000_0000, 32'h8000_0000));
    pending_reqs.push_back(mk_req(32'haaaa_aaaa, 32'h5555_5555));
    pending_reqs.push_back(mk_req(32'h5555_5555, 32'haaaa_aaaa));
    pending_reqs.push_back(mk_req(32'h1234_5678, 32'h0000_0000));
    pending_reqs.push_back(mk_req(32'h1234_5678, 32'h8765_4321));
    pending_reqs.push_back(mk_req(32'hffff_ffff, 32'hffff_ffff));
    pending_reqs.push_back(mk_req(32'h0000_0000, 32'h0000_0000));

    for (int n = 0; n < RandomReqs; n++) begin
      pending_reqs.push_back(mk_req(
          ($urandom_range(19) == 0) ? 32'd0 : $urandom(),
          ($urandom_range(1) == 0) ? 32'd0 : $urandom(),
          n == 400 || n == 900));
    end
    reqs_total = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_taken < reqs_total) @(posedge clk);
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
